>>> sv/mer_pkg.sv
package mer_pkg;

    // Field widths
    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 12;
    localparam int OUT_BITS    = COORD_BITS + 1;
    localparam int DEC_BITS    = 48;

    // Derived datapath widths
    localparam int SQ_BITS   = 2 * RADIUS_BITS;             // a^2, b^2
    localparam int K_BITS    = RADIUS_BITS + 2;             // 2x+3
    localparam int AB_BITS   = 2 * SQ_BITS;                 // a^2 * b^2
    localparam int MA_BITS   = SQ_BITS + RADIUS_BITS + 1;   // multiplier operand A
    localparam int MB_BITS   = SQ_BITS;                     // multiplier operand B
    localparam int PROD_BITS = MA_BITS + MB_BITS;

    // Input function codes
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // Multiplier operations (operand pair and destination register)
    typedef enum logic [3:0] {
        MUL_NONE   = 4'd0,
        MUL_RA_SQ  = 4'd1,   // a2  = ra * ra
        MUL_RB_SQ  = 4'd2,   // b2  = rb * rb
        MUL_A2_B2  = 4'd3,   // ab  = a2 * b2
        MUL_A2_RB  = 4'd4,   // tq  = a2 * rb
        MUL_STEP_P = 4'd5,   // tp  = b2 * (2x+3 or 2x+2)
        MUL_STEP_Q = 4'd6,   // tq  = a2 * y
        MUL_SET_P  = 4'd7,   // tp  = b2 * (x+1)
        MUL_SET_Q  = 4'd8,   // tq  = a2 * (2y-1)
        MUL_SW_1   = 4'd9,   // tp  = b2 * (2x+1)
        MUL_SW_2   = 4'd10,  // tp  = tp * (2x+1)
        MUL_SW_3   = 4'd11,  // tq  = (y-1)^2 magnitude
        MUL_SW_4   = 4'd12   // tq  = a2 * tq
    } mul_op_t;

    // Decision register updates
    typedef enum logic [1:0] {
        DEC_HOLD   = 2'd0,
        DEC_START  = 2'd1,
        DEC_STEP   = 2'd2,
        DEC_SWITCH = 2'd3
    } dec_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        dec_op_t dec_op;
        logic    step;
        logic    set_region_two;
        logic    emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic region_two;
        logic stay;
        logic last;
        logic out_free;
    } status_t;

endpackage

>>> sv/mer_if.sv
interface mer_in_if;
    import mer_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius_x;
    logic        [RADIUS_BITS-1:0] radius_y;

    modport source (
        output valid, func, center_x, center_y, radius_x, radius_y,
        input  ready
    );
    modport sink (
        input  valid, func, center_x, center_y, radius_x, radius_y,
        output ready
    );
endinterface

interface mer_out_if;
    import mer_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] right_x;
    logic signed [OUT_BITS-1:0] left_x;
    logic signed [OUT_BITS-1:0] lower_y;
    logic signed [OUT_BITS-1:0] upper_y;
    logic                       last_point;

    modport source (
        output valid, right_x, left_x, lower_y, upper_y, last_point,
        input  ready
    );
    modport sink (
        input  valid, right_x, left_x, lower_y, upper_y, last_point,
        output ready
    );
endinterface

>>> sv/mer_datapath.sv
module mer_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mer_pkg::cmd_t                     cmd,
    output mer_pkg::status_t                  status,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  center_x,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  center_y,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] radius_x,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] radius_y,
    mer_out_if.source                         points
);
    import mer_pkg::*;

    // Held item and walk state
    logic signed [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic        [RADIUS_BITS-1:0] ra_reg, rb_reg;
    logic        [RADIUS_BITS-1:0] x_reg, y_reg;
    logic        [DEC_BITS-1:0]    dec_reg, dec_next;
    logic                          region_two_reg;

    // Product registers
    logic [SQ_BITS-1:0]   a2_reg, b2_reg;
    logic [AB_BITS-1:0]   ab_reg;
    logic [PROD_BITS-1:0] tp_reg, tq_reg;

    // Output register
    logic                       out_valid_reg;
    logic signed [OUT_BITS-1:0] right_x_reg, left_x_reg, lower_y_reg, upper_y_reg;
    logic                       last_reg;

    // Operand helpers
    logic [K_BITS-1:0]      k_step;
    logic [RADIUS_BITS:0]   x_inc, y_dbl_m1, tx;
    logic [RADIUS_BITS-1:0] y_mag;
    logic                   y_zero, dec_neg;

    logic [MA_BITS-1:0]   mul_a;
    logic [MB_BITS-1:0]   mul_b;
    logic [PROD_BITS-1:0] prod;

    logic [DEC_BITS-1:0] a2e, b2e, abe, tpe, tqe;
    logic [OUT_BITS-1:0] cx_ext, cy_ext, x_ext, y_ext;

    assign y_zero   = (y_reg == '0);
    assign dec_neg  = dec_reg[DEC_BITS-1];
    assign k_step   = {1'b0, x_reg, 1'b0} + (region_two_reg ? K_BITS'(2) : K_BITS'(3));
    assign x_inc    = {1'b0, x_reg} + 1'b1;
    assign y_dbl_m1 = {y_reg, 1'b0} - 1'b1;
    assign tx       = {x_reg, 1'b1};
    assign y_mag    = y_zero ? RADIUS_BITS'(1) : (y_reg - 1'b1);

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_RA_SQ:  begin mul_a = MA_BITS'(ra_reg);  mul_b = MB_BITS'(ra_reg);   end
            MUL_RB_SQ:  begin mul_a = MA_BITS'(rb_reg);  mul_b = MB_BITS'(rb_reg);   end
            MUL_A2_B2:  begin mul_a = MA_BITS'(a2_reg);  mul_b = MB_BITS'(b2_reg);   end
            MUL_A2_RB:  begin mul_a = MA_BITS'(a2_reg);  mul_b = MB_BITS'(rb_reg);   end
            MUL_STEP_P: begin mul_a = MA_BITS'(b2_reg);  mul_b = MB_BITS'(k_step);   end
            MUL_STEP_Q: begin mul_a = MA_BITS'(a2_reg);  mul_b = MB_BITS'(y_reg);    end
            MUL_SET_P:  begin mul_a = MA_BITS'(b2_reg);  mul_b = MB_BITS'(x_inc);    end
            MUL_SET_Q:  begin mul_a = MA_BITS'(a2_reg);  mul_b = MB_BITS'(y_dbl_m1); end
            MUL_SW_1:   begin mul_a = MA_BITS'(b2_reg);  mul_b = MB_BITS'(tx);       end
            MUL_SW_2:   begin mul_a = tp_reg[MA_BITS-1:0]; mul_b = MB_BITS'(tx);     end
            MUL_SW_3:   begin mul_a = MA_BITS'(y_mag);   mul_b = MB_BITS'(y_mag);    end
            MUL_SW_4:   begin mul_a = MA_BITS'(a2_reg);  mul_b = tq_reg[MB_BITS-1:0]; end
            default:    begin mul_a = '0;                mul_b = '0;                 end
        endcase
    end

    assign prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    // Product capture
    always_ff @(posedge clk)
    begin
        case (cmd.mul_op)
            MUL_RA_SQ:  a2_reg <= prod[SQ_BITS-1:0];
            MUL_RB_SQ:  b2_reg <= prod[SQ_BITS-1:0];
            MUL_A2_B2:  ab_reg <= prod[AB_BITS-1:0];
            MUL_STEP_P, MUL_SET_P, MUL_SW_1, MUL_SW_2:
                tp_reg <= prod;
            MUL_A2_RB, MUL_STEP_Q, MUL_SET_Q, MUL_SW_3, MUL_SW_4:
                tq_reg <= prod;
            default: ;
        endcase
    end

    // Decision update, all terms mod 2^DEC_BITS
    assign a2e = DEC_BITS'(a2_reg);
    assign b2e = DEC_BITS'(b2_reg);
    assign abe = DEC_BITS'(ab_reg);
    assign tpe = DEC_BITS'(tp_reg);
    assign tqe = DEC_BITS'(tq_reg);

    always_comb
    begin
        dec_next = dec_reg;
        case (cmd.dec_op)
            DEC_START:
                dec_next = (b2e << 2) + a2e - (tqe << 2);
            DEC_STEP:
                if (!region_two_reg)
                    dec_next = dec_reg + (tpe << 2)
                             + (dec_neg ? '0 : ((a2e << 3) - (tqe << 3)));
                else
                    dec_next = dec_reg + (a2e << 3) + (a2e << 2) - (tqe << 3)
                             + (dec_neg ? (tpe << 2) : '0);
            DEC_SWITCH:
                dec_next = tpe + (tqe << 2) - (abe << 2);
            default:
                dec_next = dec_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    // Held item and offsets
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            ra_reg <= radius_x;
            rb_reg <= radius_y;
            x_reg  <= '0;
            y_reg  <= radius_y;
        end
        else if (cmd.step)
        begin
            if (!region_two_reg)
            begin
                x_reg <= x_reg + 1'b1;
                if (!dec_neg)
                    y_reg <= y_reg - 1'b1;
            end
            else
            begin
                y_reg <= y_reg - 1'b1;
                if (dec_neg)
                    x_reg <= x_reg + 1'b1;
            end
        end
    end

    // Region flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            region_two_reg <= 1'b0;
        else if (cmd.load)
            region_two_reg <= 1'b0;
        else if (cmd.set_region_two)
            region_two_reg <= 1'b1;
    end

    // Quadruple formation
    assign cx_ext = {{(OUT_BITS-COORD_BITS){cx_reg[COORD_BITS-1]}}, cx_reg};
    assign cy_ext = {{(OUT_BITS-COORD_BITS){cy_reg[COORD_BITS-1]}}, cy_reg};
    assign x_ext  = {{(OUT_BITS-RADIUS_BITS){1'b0}}, x_reg};
    assign y_ext  = {{(OUT_BITS-RADIUS_BITS){1'b0}}, y_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            right_x_reg <= $signed(cx_ext + x_ext);
            left_x_reg  <= $signed(cx_ext - x_ext);
            lower_y_reg <= $signed(cy_ext + y_ext);
            upper_y_reg <= $signed(cy_ext - y_ext);
            last_reg    <= region_two_reg && y_zero;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (points.ready)
            out_valid_reg <= 1'b0;
    end

    assign points.valid      = out_valid_reg;
    assign points.right_x    = right_x_reg;
    assign points.left_x     = left_x_reg;
    assign points.lower_y    = lower_y_reg;
    assign points.upper_y    = upper_y_reg;
    assign points.last_point = last_reg;

    // Status to controller
    assign status.region_two = region_two_reg;
    assign status.stay       = !y_zero && ({tp_reg, 1'b0} < {1'b0, tq_reg});
    assign status.last       = region_two_reg && y_zero;
    assign status.out_free   = !out_valid_reg || points.ready;

    // Checks
    region_one_step_x: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && !cmd.load && !region_two_reg |=> x_reg == $past(x_reg) + 1'b1)
        else $error("region one step did not advance x");

    region_two_step_y: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && !cmd.load && region_two_reg |=> y_reg == $past(y_reg) - 1'b1)
        else $error("region two step did not lower y");

    emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg && (last_reg == $past(region_two_reg && y_zero)))
        else $error("output register not loaded on emit");

endmodule

>>> sv/mer_ctrl.sv
module mer_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_func,
    output logic             in_ready,
    output mer_pkg::cmd_t    cmd,
    input  mer_pkg::status_t status
);
    import mer_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE     = 18'b000000000000000001,
        S_SQ_A     = 18'b000000000000000010,
        S_SQ_B     = 18'b000000000000000100,
        S_AB       = 18'b000000000000001000,
        S_A2RB     = 18'b000000000000010000,
        S_DSTART   = 18'b000000000000100000,
        S_STEP_P   = 18'b000000000001000000,
        S_STEP_Q   = 18'b000000000010000000,
        S_STEP_UPD = 18'b000000000100000000,
        S_SET_P    = 18'b000000001000000000,
        S_SET_Q    = 18'b000000010000000000,
        S_SET_TEST = 18'b000000100000000000,
        S_SW1      = 18'b000001000000000000,
        S_SW2      = 18'b000010000000000000,
        S_SW3      = 18'b000100000000000000,
        S_SW4      = 18'b001000000000000000,
        S_SW5      = 18'b010000000000000000,
        S_EMIT     = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   active_reg, active_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        in_ready    = 1'b0;
        cmd         = '{load: 1'b0, mul_op: MUL_NONE, dec_op: DEC_HOLD,
                        step: 1'b0, set_region_two: 1'b0, emit: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_START)
                    begin
                        cmd.load    = 1'b1;
                        active_next = 1'b1;
                        state_next  = S_SQ_A;
                    end
                    else if (active_reg)
                        state_next = S_STEP_P;
                end
            end
            S_SQ_A:
            begin
                cmd.mul_op = MUL_RA_SQ;
                state_next = S_SQ_B;
            end
            S_SQ_B:
            begin
                cmd.mul_op = MUL_RB_SQ;
                state_next = S_AB;
            end
            S_AB:
            begin
                cmd.mul_op = MUL_A2_B2;
                state_next = S_A2RB;
            end
            S_A2RB:
            begin
                cmd.mul_op = MUL_A2_RB;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.dec_op = DEC_START;
                state_next = S_SET_P;
            end
            S_STEP_P:
            begin
                cmd.mul_op = MUL_STEP_P;
                state_next = S_STEP_Q;
            end
            S_STEP_Q:
            begin
                cmd.mul_op = MUL_STEP_Q;
                state_next = S_STEP_UPD;
            end
            S_STEP_UPD:
            begin
                cmd.dec_op = DEC_STEP;
                cmd.step   = 1'b1;
                state_next = status.region_two ? S_EMIT : S_SET_P;
            end
            S_SET_P:
            begin
                cmd.mul_op = MUL_SET_P;
                state_next = S_SET_Q;
            end
            S_SET_Q:
            begin
                cmd.mul_op = MUL_SET_Q;
                state_next = S_SET_TEST;
            end
            S_SET_TEST:
            begin
                state_next = status.stay ? S_EMIT : S_SW1;
            end
            S_SW1:
            begin
                cmd.mul_op = MUL_SW_1;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                cmd.mul_op = MUL_SW_2;
                state_next = S_SW3;
            end
            S_SW3:
            begin
                cmd.mul_op = MUL_SW_3;
                state_next = S_SW4;
            end
            S_SW4:
            begin
                cmd.mul_op = MUL_SW_4;
                state_next = S_SW5;
            end
            S_SW5:
            begin
                cmd.dec_op         = DEC_SWITCH;
                cmd.set_region_two = 1'b1;
                state_next         = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last)
                        active_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
        end
    end

    // Checks
    start_enters_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_func == FUNC_START |=> state_reg == S_SQ_A)
        else $error("start transfer did not begin setup");

    switch_sets_region: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SW5 |=> status.region_two)
        else $error("region switch did not set region two");

    step_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP_P |-> active_reg)
        else $error("step started with no ellipse active");

    last_ends_ellipse: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && status.last |=> !active_reg)
        else $error("ellipse still active after final quadruple");

endmodule

>>> sv/midpoint_ellipse_rasterizer_top.sv
// Channel   Modport  Dir   Payload
// job       sink     in    func, center_x, center_y, radius_x, radius_y
// points    source   out   right_x, left_x, lower_y, upper_y, last_point
//
// One item at a time through one shared multiplier, one product per cycle.
// Start: squares, products, start decision, region test; switch steps too if
// region two begins at once. Advance: step and update, then in region one the
// test and any switch. An advance with no ellipse active is taken and dropped.
// Async active-low reset clears FSM, active flag, region flag and output valid.
// A stalled result waits in the output register; job is taken again once the
// FSM returns to idle, while that result may still be waiting.
module midpoint_ellipse_rasterizer_top (
    input  logic      clk,
    input  logic      rst_n,
    mer_in_if.sink    job,
    mer_out_if.source points
);
    import mer_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    ctrl_ready;

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (job.valid),
        .in_func  (job.func),
        .in_ready (ctrl_ready),
        .cmd      (cmd),
        .status   (status)
    );

    mer_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .center_x (job.center_x),
        .center_y (job.center_y),
        .radius_x (job.radius_x),
        .radius_y (job.radius_y),
        .points   (points)
    );

    assign job.ready = ctrl_ready;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mer_pkg::*;

    // Job item as driven on the input channel
    typedef struct packed {
        logic                          func;
        logic signed [COORD_BITS-1:0]  cx;
        logic signed [COORD_BITS-1:0]  cy;
        logic        [RADIUS_BITS-1:0] ra;
        logic        [RADIUS_BITS-1:0] rb;
    } job_item_t;

    // One quadruple of points
    typedef struct packed {
        logic signed [OUT_BITS-1:0] right_x;
        logic signed [OUT_BITS-1:0] left_x;
        logic signed [OUT_BITS-1:0] lower_y;
        logic signed [OUT_BITS-1:0] upper_y;
        logic                       last;
    } point_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        ROW_MODEL,      // predicted point, if any
        ROW_NO_POINT,   // known: nothing comes back
        ROW_POINT       // known point typed into the row
    } row_check_t;

    typedef struct {
        job_item_t  item;
        row_check_t chk;
        point_t     want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mer_in_if  job_ch();
    mer_out_if point_ch();

    midpoint_ellipse_rasterizer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job_ch),
        .points (point_ch)
    );

    // Ellipse walker state, mirrored from the block
    bit                          active_q;
    bit                          region_two_q;
    bit        [RADIUS_BITS-1:0] off_x;
    bit        [RADIUS_BITS-1:0] off_y;
    bit        [DEC_BITS-1:0]    dec_q;
    bit signed [COORD_BITS-1:0]  hold_cx;
    bit signed [COORD_BITS-1:0]  hold_cy;
    bit        [RADIUS_BITS-1:0] hold_ra;
    bit        [RADIUS_BITS-1:0] hold_rb;

    point_t    pending_points[$];
    stim_row_t stim_rows[$];

    int burst_left;
    int mismatches;
    int points_sent;
    int points_checked;
    int ellipses_done;
    int starts_sent;
    int advances_sent;
    int idle_advances;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic bit [63:0] square64(bit [RADIUS_BITS-1:0] v);
        bit [63:0] w;
        w = v;
        return w * w;
    endfunction

    // Move to region two once the region-one slope test fails
    function automatic void settle_region();
        bit [63:0] a2, b2, x64, y64, tx, ym1, sum;
        if (region_two_q)
            return;
        a2  = square64(hold_ra);
        b2  = square64(hold_rb);
        x64 = off_x;
        y64 = off_y;
        if (y64 != 64'd0 &&
            64'd2 * b2 * (x64 + 64'd1) < a2 * (64'd2 * y64 - 64'd1))
            return;
        region_two_q = 1'b1;
        tx  = 64'd2 * x64 + 64'd1;
        ym1 = y64 - 64'd1;
        sum = b2 * tx * tx + 64'd4 * a2 * ym1 * ym1 - 64'd4 * a2 * b2;
        dec_q = sum[DEC_BITS-1:0];
    endfunction

    function automatic void emit_point(output point_t pt);
        int cx_i, cy_i, ox_i, oy_i, s;
        cx_i = hold_cx;
        cy_i = hold_cy;
        ox_i = off_x;
        oy_i = off_y;
        s = cx_i + ox_i;
        pt.right_x = s[OUT_BITS-1:0];
        s = cx_i - ox_i;
        pt.left_x = s[OUT_BITS-1:0];
        s = cy_i + oy_i;
        pt.lower_y = s[OUT_BITS-1:0];
        s = cy_i - oy_i;
        pt.upper_y = s[OUT_BITS-1:0];
        pt.last = region_two_q && off_y == '0;
        if (pt.last)
            active_q = 1'b0;
    endfunction

    // One job item through the walker; returns 1 when a point comes out
    function automatic bit ellipse_step(input job_item_t it, output point_t pt);
        bit [63:0] a2, b2, x, y, inc, sum;
        pt = '0;
        if (it.func == FUNC_START)
        begin
            hold_cx = it.cx;
            hold_cy = it.cy;
            hold_ra = it.ra;
            hold_rb = it.rb;
            a2 = square64(hold_ra);
            b2 = square64(hold_rb);
            y  = hold_rb;
            off_x = '0;
            off_y = hold_rb;
            sum = 64'd4 * b2 + a2 - 64'd4 * a2 * y;
            dec_q = sum[DEC_BITS-1:0];
            region_two_q = 1'b0;
            active_q = 1'b1;
            settle_region();
            emit_point(pt);
            return 1'b1;
        end
        if (!active_q)
            return 1'b0;
        a2 = square64(hold_ra);
        b2 = square64(hold_rb);
        x  = off_x;
        y  = off_y;
        if (!region_two_q)
        begin
            // region one: x always steps, y on a non-negative decision
            inc = 64'd4 * b2 * (64'd2 * x + 64'd3);
            if (!dec_q[DEC_BITS-1])
            begin
                inc = inc + 64'd8 * a2 - 64'd8 * a2 * y;
                y = y - 64'd1;
            end
            sum = {16'b0, dec_q} + inc;
            dec_q = sum[DEC_BITS-1:0];
            x = x + 64'd1;
        end
        else
        begin
            // region two: y always steps, x on a negative decision
            inc = 64'd12 * a2 - 64'd8 * a2 * y;
            if (dec_q[DEC_BITS-1])
            begin
                inc = inc + 64'd4 * b2 * (64'd2 * x + 64'd2);
                x = x + 64'd1;
            end
            sum = {16'b0, dec_q} + inc;
            dec_q = sum[DEC_BITS-1:0];
            y = y - 64'd1;
        end
        off_x = x[RADIUS_BITS-1:0];
        off_y = y[RADIUS_BITS-1:0];
        settle_region();
        emit_point(pt);
        return 1'b1;
    endfunction

    function automatic job_item_t rand_item(logic f);
        job_item_t it;
        it.func = f;
        it.cx   = COORD_BITS'($urandom);
        it.cy   = COORD_BITS'($urandom);
        it.ra   = RADIUS_BITS'($urandom);
        it.rb   = RADIUS_BITS'($urandom);
        return it;
    endfunction

    task automatic add_row(logic f, int cx, int cy, int ra, int rb, row_check_t chk,
                           int rx = 0, int lx = 0, int ly = 0, int uy = 0, bit lp = 0);
        stim_row_t r;
        r.item.func     = f;
        r.item.cx       = COORD_BITS'(cx);
        r.item.cy       = COORD_BITS'(cy);
        r.item.ra       = RADIUS_BITS'(ra);
        r.item.rb       = RADIUS_BITS'(rb);
        r.chk           = chk;
        r.want.right_x  = OUT_BITS'(rx);
        r.want.left_x   = OUT_BITS'(lx);
        r.want.lower_y  = OUT_BITS'(ly);
        r.want.upper_y  = OUT_BITS'(uy);
        r.want.last     = lp;
        stim_rows.push_back(r);
    endtask

    // Drive one job transfer in bursts with random gaps, then predict
    task automatic send_item(input job_item_t it, input row_check_t chk, input point_t want,
                             output bit got, output point_t pt);
        if (burst_left == 0)
        begin
            job_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        job_ch.valid    <= 1'b1;
        job_ch.func     <= it.func;
        job_ch.center_x <= it.cx;
        job_ch.center_y <= it.cy;
        job_ch.radius_x <= it.ra;
        job_ch.radius_y <= it.rb;
        do
            @(posedge clk);
        while (!job_ch.ready);

        got = ellipse_step(it, pt);
        case (chk)
            ROW_MODEL:    if (got) pending_points.push_back(pt);
            ROW_POINT:    pending_points.push_back(want);
            ROW_NO_POINT: ;
            default:      ;
        endcase
        if (it.func == FUNC_START)
            starts_sent++;
        else if (got)
            advances_sent++;
        else
            idle_advances++;
        if (got)
            points_sent++;
    endtask

    // Hold off the sender until every pending point has come back
    task automatic drain_points();
        job_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    // Start one ellipse and walk it for up to max_adv steps
    task automatic run_ellipse(job_item_t start_it, int max_adv);
        bit     got;
        point_t pt;
        int     n;
        send_item(start_it, ROW_MODEL, '0, got, pt);
        n = 0;
        while (n < max_adv && !pt.last)
        begin
            send_item(rand_item(FUNC_ADVANCE), ROW_MODEL, '0, got, pt);
            n++;
        end
    endtask

    // Point checker and receiver stall pattern
    initial
    begin : point_monitor
        point_t got_pt, want;
        int     cyc;
        int     mode;
        cyc  = 0;
        mode = 0;
        point_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && point_ch.valid && point_ch.ready)
            begin
                got_pt.right_x = point_ch.right_x;
                got_pt.left_x  = point_ch.left_x;
                got_pt.lower_y = point_ch.lower_y;
                got_pt.upper_y = point_ch.upper_y;
                got_pt.last    = point_ch.last_point;
                if (pending_points.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR %0t: unexpected point (%0d,%0d,%0d,%0d) last=%0b",
                                 $realtime, got_pt.right_x, got_pt.left_x,
                                 got_pt.lower_y, got_pt.upper_y, got_pt.last);
                end
                else
                begin
                    want = pending_points.pop_front();
                    points_checked++;
                    if (got_pt.right_x !== want.right_x || got_pt.left_x !== want.left_x ||
                        got_pt.lower_y !== want.lower_y || got_pt.upper_y !== want.upper_y ||
                        got_pt.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR %0t: expected (%0d,%0d,%0d,%0d) last=%0b",
                                     $realtime, want.right_x, want.left_x, want.lower_y,
                                     want.upper_y, want.last);
                            $display("      got (%0d,%0d,%0d,%0d) last=%0b",
                                     got_pt.right_x, got_pt.left_x,
                                     got_pt.lower_y, got_pt.upper_y, got_pt.last);
                        end
                    end
                    if (want.last)
                        ellipses_done++;
                end
            end

            // pick a random stall mode for the receiver's ready
            cyc++;
            if (cyc % 128 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       point_ch.ready <= 1'b1;
                1:       point_ch.ready <= 1'($urandom_range(0, 1));
                2:       point_ch.ready <= ($urandom_range(0, 3) == 0);
                default: point_ch.ready <= (cyc % 7) < 4;
            endcase
        end
    end

    // Stimulus
    initial
    begin : stimulus
        bit     got;
        point_t pt;
        int     pick;
        int     rad_x, rad_y;
        job_item_t it;

        burst_left = 0;
        job_ch.valid    <= 1'b0;
        job_ch.func     <= FUNC_ADVANCE;
        job_ch.center_x <= '0;
        job_ch.center_y <= '0;
        job_ch.radius_x <= '0;
        job_ch.radius_y <= '0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: idle advance, zero size, extremes, restart, vertical run, region switch, flat ellipse
        add_row(FUNC_ADVANCE,     0,     0,    0,    0, ROW_NO_POINT);
        add_row(FUNC_START,       0,     0,    0,    0, ROW_POINT, 0, 0, 0, 0, 1);
        add_row(FUNC_ADVANCE,     0,     0,    0,    0, ROW_NO_POINT);
        add_row(FUNC_START,    2047, -2048,    0,    0, ROW_POINT,
                2047, 2047, -2048, -2048, 1);
        add_row(FUNC_START,   -2048,  2047, 1023, 1023, ROW_POINT,
                -2048, -2048, 3070, 1024, 0);
        add_row(FUNC_ADVANCE,  1234,  -777,  555,  333, ROW_MODEL);
        add_row(FUNC_ADVANCE, -2048,  2047, 1023,    0, ROW_MODEL);
        add_row(FUNC_ADVANCE,  2047, -2048,    0, 1023, ROW_MODEL);
        // start on top of a running ellipse
        add_row(FUNC_START,    2047,  2047, 1023, 1023, ROW_POINT,
                2047, 2047, 3070, 1024, 0);
        add_row(FUNC_ADVANCE,     0,     0,    0,    0, ROW_MODEL);
        add_row(FUNC_ADVANCE,     0,     0,    0,    0, ROW_MODEL);
        add_row(FUNC_START,   -2048, -2048, 1023,    0, ROW_POINT,
                -2048, -2048, -2048, -2048, 1);
        // zero radius_x: straight vertical run
        add_row(FUNC_START,       5,    -7,    0,    3, ROW_POINT, 5, 5, -4, -10, 0);
        add_row(FUNC_ADVANCE,     0,     0,    0,    0, ROW_MODEL);
        add_row(FUNC_ADVANCE,     0,     0,    0,    0, ROW_MODEL);
        add_row(FUNC_ADVANCE,     0,     0,    0,    0, ROW_MODEL);
        add_row(FUNC_ADVANCE,     0,     0,    0,    0, ROW_NO_POINT);
        // small ellipse through the region switch
        add_row(FUNC_START,     100,   200,    3,    2, ROW_MODEL);
        repeat (5)
            add_row(FUNC_ADVANCE, 0, 0, 0, 0, ROW_MODEL);
        // very flat ellipse
        add_row(FUNC_START,       0,     0, 1023,    1, ROW_MODEL);
        add_row(FUNC_ADVANCE,     0,     0,    0,    0, ROW_MODEL);

        foreach (stim_rows[i])
            send_item(stim_rows[i].item, stim_rows[i].chk, stim_rows[i].want, got, pt);

        drain_points();

        // Random part: mostly whole ellipses, some cut short, some noise
        while (points_sent < 1300)
        begin
            if ($urandom_range(0, 99) < 3)
                drain_points();
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                it = rand_item(FUNC_START);
                it.ra = RADIUS_BITS'($urandom_range(0, 24));
                it.rb = RADIUS_BITS'($urandom_range(0, 24));
                run_ellipse(it, 5000);
                // a few advances with nothing active
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 2))
                        send_item(rand_item(FUNC_ADVANCE), ROW_MODEL, '0, got, pt);
            end
            else if (pick < 88)
            begin
                // any radii, dropped by the next start
                run_ellipse(rand_item(FUNC_START), $urandom_range(0, 30));
            end
            else if (pick < 94)
            begin
                it = rand_item(FUNC_START);
                rad_x = $urandom_range(25, 150);
                rad_y = $urandom_range(25, 150);
                it.ra = RADIUS_BITS'(rad_x);
                it.rb = RADIUS_BITS'(rad_y);
                run_ellipse(it, 5000);
            end
            else
            begin
                send_item(rand_item(1'($urandom_range(0, 1))), ROW_MODEL, '0, got, pt);
            end
        end

        // Wait for the tail, then a margin past the longest step
        job_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Covered %0d ellipse starts, %0d walk steps, %0d advances with none active.",
                 starts_sent, advances_sent, idle_advances);
        $display("Checked %0d point transfers, %0d ellipses ended, %0d mismatches.",
                 points_checked, ellipses_done, mismatches);
        if (mismatches == 0 && pending_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/mer_pkg.sv
sv/mer_if.sv
sv/mer_datapath.sv
sv/mer_ctrl.sv
sv/midpoint_ellipse_rasterizer_top.sv
sim/testbench.sv
